FILE: rtl/qsalu_pkg.sv
package qsalu_pkg;

  typedef enum logic [2:0] {
    OP_FROM_INT = 3'd0,
    OP_TO_INT   = 3'd1,
    OP_MUL      = 3'd2,
    OP_DIV      = 3'd3,
    OP_CLAMP    = 3'd4
  } op_e;

  localparam int FracBits = 16;
  localparam logic signed [31:0] Int32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Int32Min = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(Int32Max)) begin
      r = Int32Max;
    end else if (v < 64'(Int32Min)) begin
      r = Int32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/q16_16_saturating_alu_core.sv
// Q16.16 saturating arithmetic unit. A word is accepted in every cycle unless
// the last stage holds a result that the output has not yet taken. Each word
// passes through the 52 stages of the pipeline: an input stage, a multiplier
// stage, a stage that scales and saturates the product, 48 stages of a
// restoring divider with one quotient bit per stage, and a stage that applies
// the sign of the quotient and saturates it. Every operation travels through
// all stages, so results leave in order. A stall at the output holds the whole
// pipeline, and nothing is lost or repeated.
module q16_16_saturating_alu_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  input  logic signed [31:0] operand_c_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [31:0] result_o
);
  import qsalu_pkg::*;

  localparam int QBits = 48;
  localparam int NStg  = QBits + 4;

  typedef struct packed {
    logic [2:0]         op;
    logic               neg;
    logic               dzero;
    logic signed [31:0] res;
    logic [31:0]        rem;
    logic [QBits-1:0]   num;
    logic [31:0]        den;
  } stg_t;

  stg_t               s_q [NStg];
  stg_t               s_d [NStg];
  logic [NStg-1:0]    v_q;
  logic               adv;
  logic signed [31:0] mul_a_q;
  logic signed [31:0] mul_b_q;
  logic signed [63:0] prod_d;
  logic signed [63:0] prod_q;

  assign adv      = ready_i || !v_q[NStg-1];
  assign ready_o  = adv;
  assign valid_o  = v_q[NStg-1];
  assign result_o = s_q[NStg-1].res;
  assign prod_d   = 64'(mul_a_q) * 64'(mul_b_q);

  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [31:0]        aa;
    logic [31:0]        bb;
    logic [31:0]        rq;
    logic signed [63:0] t;
    logic [32:0]        trial;
    logic signed [63:0] qs;
    a = operand_a_i;
    b = operand_b_i;
    c = operand_c_i;
    aa = a[31] ? 32'(-a) : 32'(a);
    bb = b[31] ? 32'(-b) : 32'(b);
    rq = aa >> FracBits;
    t = 64'(a) <<< FracBits;
    s_d[0] = '0;
    s_d[0].op = operation_i;
    s_d[0].neg = a[31] ^ b[31];
    s_d[0].dzero = (b == 32'sd0);
    s_d[0].num = {aa, 16'd0};
    s_d[0].den = bb;
    unique case (operation_i)
      OP_FROM_INT: begin
        s_d[0].res = sat32(t);
      end
      OP_TO_INT: begin
        s_d[0].res = a[31] ? 32'(-rq) : 32'(rq);
      end
      OP_DIV: begin
        if (b == 32'sd0) begin
          s_d[0].res = (a > 0) ? Int32Max : ((a < 0) ? Int32Min : 32'sd0);
        end
      end
      OP_CLAMP: begin
        s_d[0].res = (a < b) ? b : ((a > c) ? c : a);
      end
      default: s_d[0].res = '0;
    endcase
    s_d[1] = s_q[0];
    s_d[2] = s_q[1];
    if (s_q[1].op == OP_MUL) begin
      s_d[2].res = sat32(prod_q >>> FracBits);
    end
    trial = '0;
    for (int k = 3; k < NStg - 1; k++) begin
      s_d[k] = s_q[k-1];
      trial = {s_q[k-1].rem, s_q[k-1].num[QBits-1]};
      if (s_q[k-1].op == OP_DIV && !s_q[k-1].dzero) begin
        if (trial >= {1'b0, s_q[k-1].den}) begin
          s_d[k].rem = 32'(trial - {1'b0, s_q[k-1].den});
          s_d[k].num = {s_q[k-1].num[QBits-2:0], 1'b1};
        end else begin
          s_d[k].rem = trial[31:0];
          s_d[k].num = {s_q[k-1].num[QBits-2:0], 1'b0};
        end
      end
    end
    qs = 64'(s_q[NStg-2].num);
    s_d[NStg-1] = s_q[NStg-2];
    if (s_q[NStg-2].op == OP_DIV && !s_q[NStg-2].dzero) begin
      s_d[NStg-1].res = sat32(s_q[NStg-2].neg ? -qs : qs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStg-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NStg; k++) s_q[k] <= s_d[k];
      mul_a_q <= operand_a_i;
      mul_b_q <= operand_b_i;
      prod_q  <= prod_d;
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import qsalu_pkg::*;

  localparam int Latency = 52;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic [2:0] operation_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic signed [31:0] operand_c_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic signed [31:0] result_o;

  logic signed [31:0] expected_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int hold_off = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int stall_mode = 0;

  q16_16_saturating_alu_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .operation_i(operation_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .operand_c_i(operand_c_i),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .result_o(result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] saturate(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] alu_result(input logic [2:0] op,
      input logic signed [31:0] a, input logic signed [31:0] b,
      input logic signed [31:0] c);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] prod;
    logic signed [31:0] r;
    wa = a;
    wb = b;
    r = '0;
    case (op)
      OP_FROM_INT: begin
        r = saturate(wa * 64'sd65536);
      end
      OP_TO_INT: begin
        r = 32'(wa / 64'sd65536);
      end
      OP_MUL: begin
        prod = wa * wb;
        r = saturate(prod >>> 16);
      end
      OP_DIV: begin
        if (b == 0) begin
          r = (a > 0) ? 32'sh7FFF_FFFF : (a < 0) ? 32'sh8000_0000 : 32'sd0;
        end else begin
          r = saturate((wa * 64'sd65536) / wb);
        end
      end
      OP_CLAMP: begin
        if (a < b) begin
          r = b;
        end else if (a > c) begin
          r = c;
        end else begin
          r = a;
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  // Receiver: long hold-off when requested, otherwise a stall pattern that
  // changes character over the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("q16_16_saturating_alu_core test failed");
      $finish;
    end
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_off <= HoldCycles;
      ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: ready_i <= 1'b1;
        1: ready_i <= ($urandom_range(0, 3) != 0);
        2: ready_i <= ($urandom_range(0, 1) != 0);
        default: ready_i <= ((cycle_count % 7) < 4);
      endcase
    end
    if ((cycle_count % 300) == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result: unexpected word, actual %0d", result_o);
        errors <= errors + 1;
      end else if (result_o !== expected_results[0]) begin
        $error("result: expected %0d, actual %0d", expected_results[0], result_o);
        errors <= errors + 1;
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  task automatic send_word(input logic [2:0] op, input logic signed [31:0] a,
      input logic signed [31:0] b, input logic signed [31:0] c);
    valid_i <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    operand_c_i <= c;
    do @(posedge clk_i); while (!ready_o);
    expected_results.push_back(alu_result(op, a, b, c));
    words_sent++;
  endtask

  task automatic pause_sender();
    valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'sh7FFF_FFFF - $urandom_range(0, 2);
      1: v = 32'sh8000_0000 + $urandom_range(0, 2);
      2: v = $signed($urandom_range(0, 8)) - 4;
      3: v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic signed [31:0] mx;
    logic signed [31:0] mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    send_word(OP_FROM_INT, 32'sd1, 0, 0);
    send_word(OP_FROM_INT, mx, 0, 0);
    send_word(OP_FROM_INT, mn, 0, 0);
    send_word(OP_FROM_INT, -32'sd32768, 0, 0);
    send_word(OP_TO_INT, -32'sd1, 0, 0);
    send_word(OP_TO_INT, mn, 0, 0);
    send_word(OP_TO_INT, mx, 0, 0);
    send_word(OP_MUL, mx, mx, 0);
    send_word(OP_MUL, mn, mn, 0);
    send_word(OP_MUL, mn, mx, 0);
    send_word(OP_MUL, -32'sd1, 32'sd1, 0);
    send_word(OP_DIV, 32'sd5, 0, 0);
    send_word(OP_DIV, -32'sd5, 0, 0);
    send_word(OP_DIV, 0, 0, 0);
    send_word(OP_DIV, mn, -32'sd1, 0);
    send_word(OP_DIV, mx, 32'sd1, 0);
    send_word(OP_DIV, -32'sd7, 32'sd3, 0);
    send_word(OP_CLAMP, -32'sd5, 32'sd0, 32'sd10);
    send_word(OP_CLAMP, 32'sd50, 32'sd0, 32'sd10);
    send_word(OP_CLAMP, 32'sd5, 32'sd0, 32'sd10);
    send_word(OP_CLAMP, 32'sd5, 32'sd10, 32'sd0);
    send_word(OP_CLAMP, -32'sd5, 32'sd10, 32'sd0);
    send_word(3'd5, mx, mn, mx);
    send_word(3'd6, 32'sd1, 32'sd1, 32'sd1);
    send_word(3'd7, mn, mx, mn);
  endtask

  task automatic test_random(input int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender();
        burst = $urandom_range(1, 40);
      end
      burst--;
      send_word(3'($urandom_range(0, 7)), rand_operand(), rand_operand(), rand_operand());
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 100; i++) begin
      send_word(3'($urandom_range(0, 4)), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_random(350);
    test_backpressure();
    drain();
    test_random(350);
    drain();
    repeat (Latency + 20) @(posedge clk_i);
    $display("Sent %0d words covering every operation code, operand extremes and",
             words_sent);
    $display("random stalls; %0d results were checked.", results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("q16_16_saturating_alu_core test passed");
    end else begin
      $display("q16_16_saturating_alu_core test failed");
    end
    $finish;
  end

endmodule
